// ----- rtl/core/timed_sleep_priority_scheduler_assert.svh -----
// Assertion macros used by the scheduler top level.
`ifndef TIMED_SLEEP_PRIORITY_SCHEDULER_ASSERT_SVH
`define TIMED_SLEEP_PRIORITY_SCHEDULER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scheduler assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

// ----- rtl/core/tsps_pkg.sv -----
// Types, constants and helpers for the timed sleep priority scheduler.
`default_nettype none
package tsps_pkg;

  localparam int QUEUE_DEPTH  = 32;
  localparam int PRIORITY_TOP = 63;
  localparam int RESULT_LIMIT = 32;
  localparam int IdW   = 8;
  localparam int PrioW = 6;
  localparam int TickW = 32;
  localparam int CntW  = $clog2(QUEUE_DEPTH + 1);
  localparam int NW    = $clog2(RESULT_LIMIT + 1);
  localparam int InW   = 80;
  localparam int OutW  = 24;

  typedef enum logic [1:0] {
    CMD_READY = 2'd0,
    CMD_SLEEP = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_PICK  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_WOKEN  = 2'd1,
    KIND_CHOSEN = 2'd2,
    KIND_IDLE   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_TICK,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    SRC_NONE,
    SRC_READY,
    SRC_PEND
  } src_e;

  typedef enum logic {
    INS_INPUT,
    INS_SLEEP
  } ins_src_e;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } rdy_ent_t;

  typedef struct packed {
    logic [TickW-1:0] wake;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } slp_ent_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic     latch;
    logic     rdy_ins;
    ins_src_e rdy_src;
    logic     rdy_pop;
    logic     slp_ins;
    logic     slp_pop;
    logic     res_load;
    kind_e    res_kind;
    logic     res_err;
    logic     res_last;
    src_e     res_src;
    logic     pend_load;
    logic     n_clr;
    logic     n_inc;
  } dp_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic rdy_full;
    logic rdy_empty;
    logic slp_full;
    logic slp_due;
    logic n_lim;
  } dp_stat_t;

  // Clamp a requested priority to the top level
  function automatic logic [PrioW-1:0] sat_prio(input logic [PrioW-1:0] p);
    logic [PrioW-1:0] r;
    r = p;
    if (int'(p) > PRIORITY_TOP) r = PrioW'(PRIORITY_TOP);
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/timed_sleep_priority_scheduler.sv -----
// Top level of the timed sleep priority scheduler.
//
//  Channel  Dir  Transaction content
//  s_axis   in   command: cmd, thread_id, priority_req, wake_tick, now_tick
//  m_axis   out  result: kind, out_thread_id, out_priority, full_error; tlast
//
// Make ready, sleep and pick: accept, execute, then the result is offered and
// held until taken.
// A tick: accept, execute, then per woken thread a move, a report and an offer held
// until taken, and a final check; at most 32 wakes per tick.
// One transaction at a time: s_axis_tready_o is high only in the idle state.
// Reset clears both store counts; no clearing pass.
`default_nettype none
`include "timed_sleep_priority_scheduler_assert.svh"
module timed_sleep_priority_scheduler import tsps_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid_i,
  output logic                 s_axis_tready_o,
  // cmd[1:0], thread_id[9:2], priority_req[15:10], wake_tick[47:16],
  // now_tick[79:48]
  input  wire logic [InW-1:0]  s_axis_tdata_i,
  output logic                 m_axis_tvalid_o,
  input  wire logic            m_axis_tready_i,
  // kind[1:0], out_thread_id[9:2], out_priority[15:10], full_error[16],
  // zero[23:17]
  output logic [OutW-1:0]      m_axis_tdata_o,
  output logic                 m_axis_tlast_o
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  tsps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .stat_i      (dp_stat),
    .cmd_o       (dp_cmd)
  );

  tsps_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (s_axis_tdata_i),
    .cmd_i      (dp_cmd),
    .stat_o     (dp_stat),
    .out_data_o (m_axis_tdata_o),
    .out_last_o (m_axis_tlast_o)
  );

  // Never accepting while a result is offered
  `TSPS_ASSERT_NOW(a_no_overlap, clk_i, rst_ni, 1'b1, !(s_axis_tready_o && m_axis_tvalid_o))
  // An accepted command keeps the input closed next cycle
  `TSPS_ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o, !s_axis_tready_o)
  // A non-final result keeps the block busy with the same command
  `TSPS_ASSERT_NEXT(a_more_after_notlast, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tready_i && !m_axis_tlast_o, !s_axis_tready_o)

endmodule
`default_nettype wire

// ----- rtl/core/tsps_ready_q.sv -----
// Ready store: priority-sorted row of cells, highest first, FIFO on ties.
`default_nettype none
module tsps_ready_q import tsps_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     ins_i,
  input  wire logic     pop_i,
  input  wire rdy_ent_t ins_ent_i,
  output rdy_ent_t      front_o,
  output logic          full_o,
  output logic          empty_o
);

  rdy_ent_t ent_q [QUEUE_DEPTH];
  rdy_ent_t ent_d [QUEUE_DEPTH];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [QUEUE_DEPTH-1:0] ge;

  // Each valid cell whose priority is at least the new one stays ahead
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ge[i] = (CntW'(i) < cnt_q) && (ent_q[i].prio >= ins_ent_i.prio);
    end
  end

  // Cell updates: open a gap for insert, shift down for pop
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) ent_d[i] = ent_q[i];
    if (ins_i) begin
      if (!ge[0]) ent_d[0] = ins_ent_i;
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (ge[i]) ent_d[i] = ent_q[i];
        else if (ge[i-1]) ent_d[i] = ins_ent_i;
        else ent_d[i] = ent_q[i-1];
      end
    end else if (pop_i) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) ent_d[i] = ent_q[i+1];
    end
  end

  // Fill count
  always_comb begin
    cnt_d = cnt_q;
    if (ins_i) cnt_d = cnt_q + CntW'(1);
    else if (pop_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign front_o = ent_q[0];
  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule
`default_nettype wire

// ----- rtl/core/tsps_sleep_q.sv -----
// Sleep store: row of cells sorted by wake tick, then priority, then FIFO.
`default_nettype none
module tsps_sleep_q import tsps_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     ins_i,
  input  wire logic     pop_i,
  input  wire slp_ent_t ins_ent_i,
  output slp_ent_t      front_o,
  output logic          full_o,
  output logic          empty_o
);

  slp_ent_t ent_q [QUEUE_DEPTH];
  slp_ent_t ent_d [QUEUE_DEPTH];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [QUEUE_DEPTH-1:0] ahead;

  // A valid cell stays ahead unless the new entry wakes earlier or,
  // on the same tick, carries a higher priority
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      ahead[i] = (CntW'(i) < cnt_q) &&
                 !((ins_ent_i.wake < ent_q[i].wake) ||
                   ((ins_ent_i.wake == ent_q[i].wake) &&
                    (ins_ent_i.prio > ent_q[i].prio)));
    end
  end

  // Cell updates: open a gap for insert, shift down for pop
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) ent_d[i] = ent_q[i];
    if (ins_i) begin
      if (!ahead[0]) ent_d[0] = ins_ent_i;
      for (int i = 1; i < QUEUE_DEPTH; i++) begin
        if (ahead[i]) ent_d[i] = ent_q[i];
        else if (ahead[i-1]) ent_d[i] = ins_ent_i;
        else ent_d[i] = ent_q[i-1];
      end
    end else if (pop_i) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) ent_d[i] = ent_q[i+1];
    end
  end

  // Fill count
  always_comb begin
    cnt_d = cnt_q;
    if (ins_i) cnt_d = cnt_q + CntW'(1);
    else if (pop_i) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else cnt_q <= cnt_d;
  end

  always_ff @(posedge clk_i) begin
    ent_q <= ent_d;
  end

  assign front_o = ent_q[0];
  assign full_o  = (cnt_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);

endmodule
`default_nettype wire

// ----- rtl/core/tsps_datapath.sv -----
// Datapath: input and result registers, wake counter and the two stores.
`default_nettype none
module tsps_datapath import tsps_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [InW-1:0]  in_data_i,
  input  wire dp_cmd_t         cmd_i,
  output dp_stat_t             stat_o,
  output logic [OutW-1:0]      out_data_o,
  output logic                 out_last_o
);

  cmd_e             cmd_q;
  logic [IdW-1:0]   id_q;
  logic [PrioW-1:0] prio_q;
  logic [TickW-1:0] wake_q, now_q;
  rdy_ent_t         pend_q;
  logic [NW-1:0]    n_q;
  kind_e            res_kind_q;
  logic [IdW-1:0]   res_id_q;
  logic [PrioW-1:0] res_prio_q;
  logic             res_err_q, res_last_q;

  rdy_ent_t rdy_front, rdy_ins_ent, res_ent;
  slp_ent_t slp_front, slp_ins_ent;
  logic     rdy_full, rdy_empty, slp_full, slp_empty;

  // Insert sources
  always_comb begin
    if (cmd_i.rdy_src == INS_SLEEP) begin
      rdy_ins_ent.id   = slp_front.id;
      rdy_ins_ent.prio = slp_front.prio;
    end else begin
      rdy_ins_ent.id   = id_q;
      rdy_ins_ent.prio = prio_q;
    end
    slp_ins_ent.wake = wake_q;
    slp_ins_ent.id   = id_q;
    slp_ins_ent.prio = prio_q;
  end

  tsps_ready_q u_ready (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ins_i     (cmd_i.rdy_ins),
    .pop_i     (cmd_i.rdy_pop),
    .ins_ent_i (rdy_ins_ent),
    .front_o   (rdy_front),
    .full_o    (rdy_full),
    .empty_o   (rdy_empty)
  );

  tsps_sleep_q u_sleep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ins_i     (cmd_i.slp_ins),
    .pop_i     (cmd_i.slp_pop),
    .ins_ent_i (slp_ins_ent),
    .front_o   (slp_front),
    .full_o    (slp_full),
    .empty_o   (slp_empty)
  );

  // Input transaction capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      cmd_q  <= cmd_e'(in_data_i[1:0]);
      id_q   <= in_data_i[9:2];
      prio_q <= sat_prio(in_data_i[15:10]);
      wake_q <= in_data_i[47:16];
      now_q  <= in_data_i[79:48];
    end
    if (cmd_i.pend_load) begin
      pend_q.id   <= slp_front.id;
      pend_q.prio <= slp_front.prio;
    end
  end

  // Wake counter for the per-tick result limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) n_q <= '0;
    else if (cmd_i.n_clr) n_q <= '0;
    else if (cmd_i.n_inc) n_q <= n_q + NW'(1);
  end

  // Result source select
  always_comb begin
    case (cmd_i.res_src)
      SRC_READY: res_ent = rdy_front;
      SRC_PEND:  res_ent = pend_q;
      default:   res_ent = '0;
    endcase
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_kind_q <= cmd_i.res_kind;
      res_id_q   <= res_ent.id;
      res_prio_q <= res_ent.prio;
      res_err_q  <= cmd_i.res_err;
      res_last_q <= cmd_i.res_last;
    end
  end

  assign stat_o.cmd       = cmd_q;
  assign stat_o.rdy_full  = rdy_full;
  assign stat_o.rdy_empty = rdy_empty;
  assign stat_o.slp_full  = slp_full;
  assign stat_o.slp_due   = !slp_empty && (slp_front.wake <= now_q);
  assign stat_o.n_lim     = (n_q == NW'(RESULT_LIMIT));

  assign out_data_o = {7'b0, res_err_q, res_prio_q, res_id_q, res_kind_q};
  assign out_last_o = res_last_q;

endmodule
`default_nettype wire

// ----- rtl/core/tsps_ctrl.sv -----
// Controller: sequences commands, tick wake walk and result hand-off.
`default_nettype none
module tsps_ctrl import tsps_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  state_e state_q, state_d;
  logic   ret_q, ret_d;
  logic   pend_q, pend_d;
  logic   cont;

  assign cont = stat_i.slp_due && !stat_i.n_lim;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_EXEC;
      ST_EXEC: begin
        if (stat_i.cmd == CMD_TICK) state_d = ST_TICK;
        else state_d = ST_OUT;
      end
      ST_TICK: begin
        if (pend_q) state_d = ST_OUT;
        else if (!cont) state_d = ST_IDLE;
        else if (stat_i.rdy_full) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ret_q ? ST_TICK : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs and commands
  always_comb begin
    cmd_o       = '0;
    ret_d       = ret_q;
    pend_d      = pend_q;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
        cmd_o.n_clr = in_valid_i;
        pend_d      = 1'b0;
      end
      ST_EXEC: begin
        ret_d = 1'b0;
        case (stat_i.cmd)
          CMD_READY: begin
            cmd_o.rdy_ins  = !stat_i.rdy_full;
            cmd_o.rdy_src  = INS_INPUT;
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = KIND_ACK;
            cmd_o.res_err  = stat_i.rdy_full;
            cmd_o.res_last = 1'b1;
            cmd_o.res_src  = SRC_NONE;
          end
          CMD_SLEEP: begin
            cmd_o.slp_ins  = !stat_i.slp_full;
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = KIND_ACK;
            cmd_o.res_err  = stat_i.slp_full;
            cmd_o.res_last = 1'b1;
            cmd_o.res_src  = SRC_NONE;
          end
          CMD_PICK: begin
            cmd_o.rdy_pop  = !stat_i.rdy_empty;
            cmd_o.res_load = 1'b1;
            cmd_o.res_kind = stat_i.rdy_empty ? KIND_IDLE : KIND_CHOSEN;
            cmd_o.res_last = 1'b1;
            cmd_o.res_src  = stat_i.rdy_empty ? SRC_NONE : SRC_READY;
          end
          default: ;
        endcase
      end
      ST_TICK: begin
        if (pend_q) begin
          // Woken report; last when no further result follows
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = KIND_WOKEN;
          cmd_o.res_last = !cont;
          cmd_o.res_src  = SRC_PEND;
          pend_d         = 1'b0;
          ret_d          = 1'b1;
        end else if (cont && stat_i.rdy_full) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_kind = KIND_ACK;
          cmd_o.res_err  = 1'b1;
          cmd_o.res_last = 1'b1;
          cmd_o.res_src  = SRC_NONE;
          ret_d          = 1'b0;
        end else if (cont) begin
          // Move sleep front into the ready store
          cmd_o.slp_pop   = 1'b1;
          cmd_o.rdy_ins   = 1'b1;
          cmd_o.rdy_src   = INS_SLEEP;
          cmd_o.pend_load = 1'b1;
          cmd_o.n_inc     = 1'b1;
          pend_d          = 1'b1;
        end
      end
      ST_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      pend_q  <= pend_d;
    end
  end

endmodule
`default_nettype wire
